@@ hdl/tffn_pkg.sv @@
package tffn_pkg;

   localparam int FRAC_BITS = 14;
   localparam int UNIT_W    = 16;
   localparam int QUO_W     = 15;
   localparam int CFG_W     = 36;
   localparam int ROOT_W    = 64;
   localparam int CR_W      = 32;
   localparam int ERR_W     = 2;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE,
      ERR_SHORT_FIBER,
      ERR_SHORT_SHEET,
      ERR_ZERO_NORMAL
   } err_type;

   typedef enum logic [1:0] {
      PH_FIBER,
      PH_SHEET,
      PH_NORMAL
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_CHECK,
      ST_ROOT,
      ST_LOAD,
      ST_DIVIDE,
      ST_CROSS,
      ST_NCHECK,
      ST_OUT
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ hdl/tffn_if.sv @@
interface tffn_req_if #(parameter int COMPONENT_WIDTH = 16) ();
   logic                              valid;
   logic                              ready;
   logic signed [COMPONENT_WIDTH-1:0] fiber_x;
   logic signed [COMPONENT_WIDTH-1:0] fiber_y;
   logic signed [COMPONENT_WIDTH-1:0] fiber_z;
   logic signed [COMPONENT_WIDTH-1:0] sheet_x;
   logic signed [COMPONENT_WIDTH-1:0] sheet_y;
   logic signed [COMPONENT_WIDTH-1:0] sheet_z;

   modport source (output valid, fiber_x, fiber_y, fiber_z, sheet_x, sheet_y, sheet_z,
                   input ready);
   modport sink   (input valid, fiber_x, fiber_y, fiber_z, sheet_x, sheet_y, sheet_z,
                   output ready);
endinterface

interface tffn_rsp_if import tffn_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [UNIT_W-1:0] unit_fiber_x;
   logic signed [UNIT_W-1:0] unit_fiber_y;
   logic signed [UNIT_W-1:0] unit_fiber_z;
   logic signed [UNIT_W-1:0] unit_sheet_x;
   logic signed [UNIT_W-1:0] unit_sheet_y;
   logic signed [UNIT_W-1:0] unit_sheet_z;
   logic signed [UNIT_W-1:0] unit_normal_x;
   logic signed [UNIT_W-1:0] unit_normal_y;
   logic signed [UNIT_W-1:0] unit_normal_z;
   logic [ERR_W-1:0]         error_code;

   modport source (output valid, unit_fiber_x, unit_fiber_y, unit_fiber_z,
                   unit_sheet_x, unit_sheet_y, unit_sheet_z,
                   unit_normal_x, unit_normal_y, unit_normal_z, error_code,
                   input ready);
   modport sink   (input valid, unit_fiber_x, unit_fiber_y, unit_fiber_z,
                   unit_sheet_x, unit_sheet_y, unit_sheet_z,
                   unit_normal_x, unit_normal_y, unit_normal_z, error_code,
                   output ready);
endinterface

@@ hdl/tffn_front.sv @@
module tffn_front import tffn_pkg::*; #(
   parameter int VERTS_PER_ELEMENT = 4,
   parameter int COMPONENT_WIDTH   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   tffn_req_if.sink                            req_chan,
   input  queue_status_type                    q_status,
   output logic                                push,
   output logic [6*(COMPONENT_WIDTH+2)-1:0]    push_data
);

   localparam int ACC_W = COMPONENT_WIDTH + 2;
   localparam int CNT_W = (VERTS_PER_ELEMENT > 1) ? $clog2(VERTS_PER_ELEMENT) : 1;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(VERTS_PER_ELEMENT - 1);

   logic signed [ACC_W-1:0] acc_ff [6];
   logic signed [ACC_W-1:0] acc_in [6];
   logic signed [ACC_W-1:0] item [6];
   logic signed [ACC_W-1:0] sum [6];
   logic [CNT_W-1:0]        cnt_ff;
   logic [CNT_W-1:0]        cnt_in;
   logic                    accept;

   assign req_chan.ready = !q_status.full;
   assign accept = req_chan.valid && req_chan.ready;

   assign item[0] = {{2{req_chan.fiber_x[COMPONENT_WIDTH-1]}}, req_chan.fiber_x};
   assign item[1] = {{2{req_chan.fiber_y[COMPONENT_WIDTH-1]}}, req_chan.fiber_y};
   assign item[2] = {{2{req_chan.fiber_z[COMPONENT_WIDTH-1]}}, req_chan.fiber_z};
   assign item[3] = {{2{req_chan.sheet_x[COMPONENT_WIDTH-1]}}, req_chan.sheet_x};
   assign item[4] = {{2{req_chan.sheet_y[COMPONENT_WIDTH-1]}}, req_chan.sheet_y};
   assign item[5] = {{2{req_chan.sheet_z[COMPONENT_WIDTH-1]}}, req_chan.sheet_z};

   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      push   = 1'b0;
      for (int k = 0; k < 6; k++) begin
         sum[k] = acc_ff[k] + item[k];
         push_data[k*ACC_W +: ACC_W] = sum[k];
      end
      if (accept) begin
         if (cnt_ff == LAST_CNT) begin
            // The finished element goes to the queue and the sums start over.
            push   = 1'b1;
            cnt_in = '0;
            for (int k = 0; k < 6; k++) acc_in[k] = '0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            acc_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         for (int k = 0; k < 6; k++) acc_ff[k] <= '0;
      end else begin
         cnt_ff <= cnt_in;
         acc_ff <= acc_in;
      end
   end

endmodule

@@ hdl/tffn_queue.sv @@
module tffn_queue import tffn_pkg::*; #(
   parameter int WIDTH = 108
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type q_status
);

   logic [WIDTH-1:0] ent_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       cnt_ff;

   assign pop_data       = ent_ff[rd_ptr_ff];
   assign q_status.full  = cnt_ff[1];
   assign q_status.empty = (cnt_ff == 2'd0);

   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

@@ hdl/tffn_back.sv @@
module tffn_back import tffn_pkg::*; #(
   parameter int COMPONENT_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [CFG_W-1:0]                 min_length_squared,
   input  logic [6*(COMPONENT_WIDTH+2)-1:0] pop_data,
   input  queue_status_type                 q_status,
   output logic                             pop,
   tffn_rsp_if.source                       rsp_chan
);

   localparam int ACC_W = COMPONENT_WIDTH + 2;
   localparam int MUL_W = (ACC_W > CR_W) ? ACC_W : CR_W;
   localparam int KW    = $clog2(QUO_W);
   localparam logic [3:0] NORMAL_BASE = 4'd6;
   localparam logic [2:0] IDX_FIBER_END = 3'd2;
   localparam logic [2:0] IDX_SHEET_END = 3'd5;
   localparam logic [2:0] IDX_SHEET_BASE = 3'd3;

   back_state_type          state_ff, state_in;
   phase_type               ph_ff, ph_in;
   err_type                 err_ff, err_in;
   logic [2:0]              idx_ff, idx_in;
   logic signed [ACC_W-1:0] vec_ff [6];
   logic signed [ACC_W-1:0] vec_in [6];
   logic signed [CR_W-1:0]  cross_ff [3];
   logic signed [CR_W-1:0]  cross_in [3];
   logic signed [UNIT_W-1:0] unit_ff [9];
   logic signed [UNIT_W-1:0] unit_in [9];
   logic [ROOT_W-1:0]       len_sq_ff [3];
   logic [ROOT_W-1:0]       len_sq_in [3];
   logic [ROOT_W-1:0]       root_v_ff, root_v_in;
   logic [ROOT_W-1:0]       root_r_ff, root_r_in;
   logic [ROOT_W-1:0]       root_bit_ff, root_bit_in;
   logic [ROOT_W-1:0]       rem_ff, rem_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic [KW-1:0]           k_ff, k_in;
   logic signed [UNIT_W-1:0] out_ff [9];
   logic signed [UNIT_W-1:0] out_in [9];
   err_type                 out_err_ff, out_err_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic signed [ROOT_W-1:0] src_s;
   logic [ROOT_W-1:0]        src_mag;
   logic                     src_neg;
   logic signed [MUL_W:0]    mul_a, mul_b;
   logic signed [2*MUL_W+1:0] product;
   logic [ROOT_W-1:0]        prod64;
   logic signed [CR_W-1:0]   cp;
   logic [3:0]               uidx;
   logic [1:0]               cr_idx;
   logic [1:0]               sq_idx;
   logic [ROOT_W-1:0]        thr64;
   logic [ROOT_W-1:0]        root_sum;
   logic [ROOT_W-1:0]        trial;
   logic [UNIT_W-1:0]        q16;

   function automatic logic signed [MUL_W:0] ext_unit(input logic signed [UNIT_W-1:0] u);
      return {{(MUL_W+1-UNIT_W){u[UNIT_W-1]}}, u};
   endfunction

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.unit_fiber_x  = out_ff[0];
   assign rsp_chan.unit_fiber_y  = out_ff[1];
   assign rsp_chan.unit_fiber_z  = out_ff[2];
   assign rsp_chan.unit_sheet_x  = out_ff[3];
   assign rsp_chan.unit_sheet_y  = out_ff[4];
   assign rsp_chan.unit_sheet_z  = out_ff[5];
   assign rsp_chan.unit_normal_x = out_ff[6];
   assign rsp_chan.unit_normal_y = out_ff[7];
   assign rsp_chan.unit_normal_z = out_ff[8];
   assign rsp_chan.error_code    = out_err_ff;

   assign thr64 = {{(ROOT_W-CFG_W){1'b0}}, min_length_squared};

   // Operand of the squares and divides: a summed component or a cross component.
   always_comb begin
      if (ph_ff == PH_NORMAL) begin
         src_s = {{(ROOT_W-CR_W){cross_ff[idx_ff[1:0]][CR_W-1]}}, cross_ff[idx_ff[1:0]]};
      end else begin
         src_s = {{(ROOT_W-ACC_W){vec_ff[idx_ff][ACC_W-1]}}, vec_ff[idx_ff]};
      end
      src_neg = src_s[ROOT_W-1];
      src_mag = src_neg ? ROOT_W'(-src_s) : ROOT_W'(src_s);
   end

   // One shared multiplier: squares of magnitudes, or unit products for the cross.
   always_comb begin
      mul_a = {1'b0, src_mag[MUL_W-1:0]};
      mul_b = {1'b0, src_mag[MUL_W-1:0]};
      if (state_ff == ST_CROSS) begin
         case (idx_ff)
            3'd0:    begin mul_a = ext_unit(unit_ff[1]); mul_b = ext_unit(unit_ff[5]); end
            3'd1:    begin mul_a = ext_unit(unit_ff[2]); mul_b = ext_unit(unit_ff[4]); end
            3'd2:    begin mul_a = ext_unit(unit_ff[2]); mul_b = ext_unit(unit_ff[3]); end
            3'd3:    begin mul_a = ext_unit(unit_ff[0]); mul_b = ext_unit(unit_ff[5]); end
            3'd4:    begin mul_a = ext_unit(unit_ff[0]); mul_b = ext_unit(unit_ff[4]); end
            3'd5:    begin mul_a = ext_unit(unit_ff[1]); mul_b = ext_unit(unit_ff[3]); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
      product = mul_a * mul_b;
      prod64  = product[ROOT_W-1:0];
      cp      = product[CR_W-1:0];
   end

   assign pop = (state_ff == ST_IDLE) && !q_status.empty;

   always_comb begin
      state_in     = state_ff;
      ph_in        = ph_ff;
      err_in       = err_ff;
      idx_in       = idx_ff;
      vec_in       = vec_ff;
      cross_in     = cross_ff;
      unit_in      = unit_ff;
      len_sq_in    = len_sq_ff;
      root_v_in    = root_v_ff;
      root_r_in    = root_r_ff;
      root_bit_in  = root_bit_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      k_in         = k_ff;
      out_in       = out_ff;
      out_err_in   = out_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      uidx     = (ph_ff == PH_NORMAL) ? ({1'b0, idx_ff} + NORMAL_BASE) : {1'b0, idx_ff};
      cr_idx   = idx_ff[2:1];
      sq_idx   = (ph_ff == PH_NORMAL) ? 2'd2 : ((idx_ff < IDX_SHEET_BASE) ? 2'd0 : 2'd1);
      root_sum = root_r_ff + root_bit_ff;
      trial    = root_r_ff << k_ff;
      q16      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               for (int k = 0; k < 6; k++) vec_in[k] = $signed(pop_data[k*ACC_W +: ACC_W]);
               len_sq_in[0] = '0;
               len_sq_in[1] = '0;
               idx_in   = '0;
               ph_in    = PH_FIBER;
               err_in   = ERR_NONE;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            len_sq_in[sq_idx] = len_sq_ff[sq_idx] + prod64;
            idx_in = idx_ff + 3'd1;
            if (ph_ff == PH_NORMAL && idx_ff == IDX_FIBER_END) state_in = ST_NCHECK;
            else if (idx_ff == IDX_SHEET_END) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // The fiber test takes precedence over the sheet test.
            if (len_sq_ff[0] == '0 || len_sq_ff[0] < thr64) begin
               err_in   = ERR_SHORT_FIBER;
               state_in = ST_OUT;
            end else if (len_sq_ff[1] == '0 || len_sq_ff[1] < thr64) begin
               err_in   = ERR_SHORT_SHEET;
               state_in = ST_OUT;
            end else begin
               root_v_in   = len_sq_ff[0];
               root_r_in   = '0;
               root_bit_in = ROOT_W'(1) << (ROOT_W - 2);
               state_in    = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_v_ff >= root_sum) begin
               root_v_in = root_v_ff - root_sum;
               root_r_in = (root_r_ff >> 1) + root_bit_ff;
            end else begin
               root_r_in = root_r_ff >> 1;
            end
            root_bit_in = root_bit_ff >> 2;
            if (root_bit_ff[0]) begin
               idx_in   = (ph_ff == PH_SHEET) ? IDX_SHEET_BASE : 3'd0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            rem_in   = src_mag << FRAC_BITS;
            quo_in   = '0;
            k_in     = KW'(QUO_W - 1);
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            // Restoring division, one quotient bit a cycle from the top.
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               quo_in = quo_ff | (QUO_W'(1) << k_ff);
            end
            k_in = k_ff - 1'b1;
            if (k_ff == '0) begin
               q16 = {1'b0, quo_in};
               unit_in[uidx] = src_neg ? $signed(-q16) : $signed(q16);
               if (idx_ff == IDX_FIBER_END || idx_ff == IDX_SHEET_END) begin
                  case (ph_ff)
                     PH_FIBER: begin
                        ph_in       = PH_SHEET;
                        root_v_in   = len_sq_ff[1];
                        root_r_in   = '0;
                        root_bit_in = ROOT_W'(1) << (ROOT_W - 2);
                        state_in    = ST_ROOT;
                     end
                     PH_SHEET: begin
                        idx_in   = '0;
                        state_in = ST_CROSS;
                     end
                     default: begin
                        state_in = ST_OUT;
                     end
                  endcase
               end else begin
                  idx_in   = idx_ff + 3'd1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_CROSS: begin
            cross_in[cr_idx] = idx_ff[0] ? (cross_ff[cr_idx] - cp) : cp;
            idx_in = idx_ff + 3'd1;
            if (idx_ff == IDX_SHEET_END) begin
               idx_in       = '0;
               ph_in        = PH_NORMAL;
               len_sq_in[2] = '0;
               state_in     = ST_SQUARE;
            end
         end
         ST_NCHECK: begin
            if (len_sq_ff[2] == '0) begin
               err_in   = ERR_ZERO_NORMAL;
               state_in = ST_OUT;
            end else begin
               root_v_in   = len_sq_ff[2];
               root_r_in   = '0;
               root_bit_in = ROOT_W'(1) << (ROOT_W - 2);
               state_in    = ST_ROOT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               for (int k = 0; k < 9; k++) out_in[k] = (err_ff == ERR_NONE) ? unit_ff[k] : '0;
               out_err_in   = err_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ph_ff       <= ph_in;
      err_ff      <= err_in;
      idx_ff      <= idx_in;
      vec_ff      <= vec_in;
      cross_ff    <= cross_in;
      unit_ff     <= unit_in;
      len_sq_ff   <= len_sq_in;
      root_v_ff   <= root_v_in;
      root_r_ff   <= root_r_in;
      root_bit_ff <= root_bit_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      k_ff        <= k_in;
      out_ff      <= out_in;
      out_err_ff  <= out_err_in;
   end

endmodule

@@ hdl/tet_fiber_frame_normalizer_unit.sv @@
// Channel   Direction  Handshake         Payload
// req_chan  in         valid/ready       fiber_x/y/z, sheet_x/y/z (one vertex)
// rsp_chan  out        valid/ready       unit fiber, sheet, normal, error_code
// csr_*     in         write enable      min_length_squared
//
// Vertices are taken in one cycle each while the element queue has room.
// Each element then passes through the back end, which runs the one-bit-per-cycle
// square root (32 steps, three per element) and the restoring divider (15 steps,
// nine per element).
// Reset is synchronous and clears the sums, the vertex count, the queue and the
// result valid flag. A stalled result stays in its register while the back end
// works on the next element.
module tet_fiber_frame_normalizer_unit import tffn_pkg::*; #(
   parameter int VERTS_PER_ELEMENT = 4,
   parameter int COMPONENT_WIDTH   = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [CFG_W-1:0] csr_write_data,
   tffn_req_if.sink         req_chan,
   tffn_rsp_if.source       rsp_chan
);

   localparam int ELEM_W = 6 * (COMPONENT_WIDTH + 2);

   logic [CFG_W-1:0]  thr_ff;
   logic              push;
   logic              pop;
   logic [ELEM_W-1:0] push_data;
   logic [ELEM_W-1:0] pop_data;
   queue_status_type  q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= CFG_W'(1);
      end else if (csr_write_enable) begin
         thr_ff <= csr_write_data;
      end
   end

   tffn_front #(
      .VERTS_PER_ELEMENT (VERTS_PER_ELEMENT),
      .COMPONENT_WIDTH   (COMPONENT_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   tffn_queue #(
      .WIDTH (ELEM_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_status  (q_status)
   );

   tffn_back #(
      .COMPONENT_WIDTH (COMPONENT_WIDTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .min_length_squared (thr_ff),
      .pop_data           (pop_data),
      .q_status           (q_status),
      .pop                (pop),
      .rsp_chan           (rsp_chan)
   );

endmodule

@@ hdl/tffn_checker.sv @@
module tffn_checker import tffn_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [UNIT_W-1:0] unit_fiber_x,
   input logic signed [UNIT_W-1:0] unit_sheet_x,
   input logic signed [UNIT_W-1:0] unit_normal_x,
   input logic signed [UNIT_W-1:0] unit_normal_y,
   input logic signed [UNIT_W-1:0] unit_normal_z,
   input logic [ERR_W-1:0]         error_code
);

   localparam logic signed [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1 << FRAC_BITS);

   // A result waiting to be taken is not withdrawn.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // Every error reports zero in the fiber x, sheet x and normal components.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && error_code != ERR_NONE |->
         unit_fiber_x == '0 && unit_sheet_x == '0 && unit_normal_x == '0 &&
         unit_normal_y == '0 && unit_normal_z == '0)
      else $error("nonzero vector with error code");

   // A good frame has fiber x and normal x components of at most one in magnitude.
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && error_code == ERR_NONE |->
         unit_fiber_x <= UNIT_ONE && unit_fiber_x >= -UNIT_ONE &&
         unit_normal_x <= UNIT_ONE && unit_normal_x >= -UNIT_ONE)
      else $error("unit component out of range");

   // Nothing is offered in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind tet_fiber_frame_normalizer_unit tffn_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .unit_fiber_x  (rsp_chan.unit_fiber_x),
   .unit_sheet_x  (rsp_chan.unit_sheet_x),
   .unit_normal_x (rsp_chan.unit_normal_x),
   .unit_normal_y (rsp_chan.unit_normal_y),
   .unit_normal_z (rsp_chan.unit_normal_z),
   .error_code    (rsp_chan.error_code)
);
